// ===== hdl/sshd_pkg.sv =====
// ----------------------------------------------------------------------------
// sshd_pkg
// types and constants shared by the packet deframer modules
// ----------------------------------------------------------------------------
package sshd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned SeqW    = 32;
  localparam int unsigned ErrW    = 3;
  localparam int unsigned MaxW    = 16;
  localparam int unsigned LenW    = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [MaxW-1:0] MAX_BYTES_RESET = 16'd35000;
  localparam logic [LenW-1:0] MIN_LENGTH      = 32'd12;
  localparam logic [ByteW-1:0] MIN_PADDING    = 8'd4;

  localparam logic [CfgIdxW-1:0] REG_CIPHER_ACTIVE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_BYTES     = 2'd1;

  typedef enum logic [ErrW-1:0] {
    ERR_NONE      = 3'd0,
    ERR_LEN_SHORT = 3'd1,
    ERR_LEN_LONG  = 3'd2,
    ERR_MISALIGN  = 3'd3,
    ERR_PAD_SHORT = 3'd4,
    ERR_PAD_LONG  = 3'd5
  } sshd_err_t;

  typedef struct packed {
    logic [ErrW-1:0]  error_code;
    logic [SeqW-1:0]  packet_seq;
    logic             last;
    logic [ByteW-1:0] payload_byte;
  } sshd_result_t;

endpackage

// ===== hdl/sshd_in_stage.sv =====
// ----------------------------------------------------------------------------
// sshd_in_stage
// input register holding one link byte until the framing logic takes it
// ----------------------------------------------------------------------------
module sshd_in_stage (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [sshd_pkg::ByteW-1:0] s_byte,
  output logic                     in_valid,
  output logic [sshd_pkg::ByteW-1:0] in_byte,
  input  logic                     take
);
  import sshd_pkg::*;

  logic             valid;
  logic [ByteW-1:0] data;

  assign s_tready = !valid || take;
  assign in_valid = valid;
  assign in_byte  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      data <= s_byte;
    end
  end

endmodule

// ===== hdl/sshd_core.sv =====
// ----------------------------------------------------------------------------
// sshd_core
// framing state, length and padding checks, configuration registers
// ----------------------------------------------------------------------------
module sshd_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic [sshd_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [sshd_pkg::MaxW-1:0]   cfg_data,
  input  logic                        in_valid,
  input  logic [sshd_pkg::ByteW-1:0]  in_byte,
  output logic                        take,
  input  logic                        res_ready,
  output logic                        res_valid,
  output sshd_pkg::sshd_result_t      res
);
  import sshd_pkg::*;

  typedef enum logic [2:0] {
    PH_LENGTH,
    PH_PADLEN,
    PH_PAYLOAD,
    PH_PADDING,
    PH_DEAD
  } phase_t;

  phase_t           phase, phase_next;
  logic             cipher_active;
  logic [MaxW-1:0]  max_packet_bytes;
  logic [LenW-1:0]  length_acc, length_acc_next;
  logic [1:0]       len_cnt, len_cnt_next;
  logic [MaxW-1:0]  payload_cnt, payload_cnt_next;
  logic [ByteW-1:0] padding_cnt, padding_cnt_next;
  logic [SeqW-1:0]  seq, seq_next;

  logic [LenW-1:0]  len_full;
  logic [MaxW:0]    total;
  logic             len_long;
  logic             misaligned;
  logic [MaxW:0]    pad_plus2;
  sshd_err_t        err;
  logic             produces;

  assign len_full   = {length_acc[LenW-ByteW-1:0], in_byte};
  assign total      = {1'b0, len_full[MaxW-1:0]} + (MaxW+1)'(4);
  assign len_long   = (len_full[LenW-1:MaxW] != '0) || (total > {1'b0, max_packet_bytes});
  assign misaligned = cipher_active ? (len_full[3:0] != 4'd12) : (len_full[2:0] != 3'd4);
  assign pad_plus2  = (MaxW+1)'(in_byte) + (MaxW+1)'(2);

  always_comb begin
    phase_next       = phase;
    length_acc_next  = length_acc;
    len_cnt_next     = len_cnt;
    payload_cnt_next = payload_cnt;
    padding_cnt_next = padding_cnt;
    seq_next         = seq;
    err              = ERR_NONE;
    produces         = 1'b0;
    res.payload_byte = '0;
    res.last         = 1'b0;
    res.packet_seq   = seq;
    res.error_code   = ERR_NONE;
    case (phase)
      PH_LENGTH: begin
        length_acc_next = len_full;
        len_cnt_next    = len_cnt + 2'd1;
        if (len_cnt == 2'd3) begin
          if (len_full < MIN_LENGTH) begin
            err = ERR_LEN_SHORT;
          end else if (len_long) begin
            err = ERR_LEN_LONG;
          end else if (misaligned) begin
            err = ERR_MISALIGN;
          end
          if (err != ERR_NONE) begin
            produces   = 1'b1;
            phase_next = PH_DEAD;
          end else begin
            phase_next = PH_PADLEN;
          end
        end
      end
      PH_PADLEN: begin
        if (in_byte < MIN_PADDING) begin
          err = ERR_PAD_SHORT;
        end else if (pad_plus2 > {1'b0, length_acc[MaxW-1:0]}) begin
          err = ERR_PAD_LONG;
        end
        if (err != ERR_NONE) begin
          produces   = 1'b1;
          phase_next = PH_DEAD;
        end else begin
          padding_cnt_next = in_byte;
          payload_cnt_next = length_acc[MaxW-1:0] - MaxW'(1) - MaxW'(in_byte);
          phase_next       = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        produces         = 1'b1;
        payload_cnt_next = payload_cnt - MaxW'(1);
        res.payload_byte = in_byte;
        res.last         = (payload_cnt == MaxW'(1));
        if (payload_cnt == MaxW'(1)) begin
          phase_next = PH_PADDING;
        end
      end
      PH_PADDING: begin
        padding_cnt_next = padding_cnt - ByteW'(1);
        if (padding_cnt == ByteW'(1)) begin
          seq_next        = seq + SeqW'(1);
          length_acc_next = '0;
          len_cnt_next    = '0;
          phase_next      = PH_LENGTH;
        end
      end
      PH_DEAD: begin
      end
      default: begin
        phase_next = PH_DEAD;
      end
    endcase
    res.error_code = err;
  end

  assign take      = in_valid && (!produces || res_ready);
  assign res_valid = in_valid && produces && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_LENGTH;
      length_acc       <= '0;
      len_cnt          <= '0;
      payload_cnt      <= '0;
      padding_cnt      <= '0;
      seq              <= '0;
      cipher_active    <= 1'b0;
      max_packet_bytes <= MAX_BYTES_RESET;
    end else begin
      if (take) begin
        phase       <= phase_next;
        length_acc  <= length_acc_next;
        len_cnt     <= len_cnt_next;
        payload_cnt <= payload_cnt_next;
        padding_cnt <= padding_cnt_next;
        seq         <= seq_next;
      end
      if (cfg_valid && cfg_index == REG_CIPHER_ACTIVE) begin
        cipher_active <= cfg_data[0];
      end
      if (cfg_valid && cfg_index == REG_MAX_BYTES) begin
        max_packet_bytes <= cfg_data;
      end
    end
  end

endmodule

// ===== hdl/sshd_out_reg.sv =====
// ----------------------------------------------------------------------------
// sshd_out_reg
// result register towards the master side
// ----------------------------------------------------------------------------
module sshd_out_reg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   res_valid,
  input  sshd_pkg::sshd_result_t res,
  output logic                   res_ready,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output sshd_pkg::sshd_result_t m_res
);
  import sshd_pkg::*;

  logic         valid;
  sshd_result_t data;

  assign res_ready = !valid || m_tready;
  assign m_tvalid  = valid;
  assign m_res     = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (res_ready) begin
      valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      data <= res;
    end
  end

endmodule

// ===== hdl/ssh_packet_deframer_top.sv =====
// A decrypted SSH packet stream enters one byte per beat and may be offered in
// every clock. Bytes that give no result beat are taken one per cycle at all
// times; a byte that gives a result beat waits in the input register only while
// the result register still holds a beat that the master side has not taken.
// The result register loads on the clock on which the framing logic takes the
// byte from the input register. Length, alignment and padding errors give one
// beat with tuser set, after which every byte is swallowed until reset.
// ----------------------------------------------------------------------------
// ssh_packet_deframer_top
// ssh binary packet deframer, plaintext side
// ----------------------------------------------------------------------------
module ssh_packet_deframer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,   // cipher_active [0] or max_packet_bytes [15:0]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // link_byte [7:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,    // payload_byte [7:0], packet_seq [39:8]
  output logic        m_tlast,
  output logic [2:0]  m_tuser     // error_code [2:0]
);
  import sshd_pkg::*;

  logic             in_valid;
  logic [ByteW-1:0] in_byte;
  logic             take;
  logic             res_valid;
  logic             res_ready;
  sshd_result_t     res;
  sshd_result_t     m_res;

  assign cfg_ready = 1'b1;

  sshd_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_byte   (s_tdata),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .take     (take)
  );

  sshd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_byte   (in_byte),
    .take      (take),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  sshd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_res     (m_res)
  );

  assign m_tdata = {m_res.packet_seq, m_res.payload_byte};
  assign m_tlast = m_res.last;
  assign m_tuser = m_res.error_code;

`ifndef SYNTHESIS
  a_err_beat_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ERR_NONE) |-> (m_tdata[7:0] == 8'd0 && !m_tlast))
    else $error("error beat carries payload or last");

  a_dead_after_err: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tuser != ERR_NONE) |=> !m_tvalid)
    else $error("result beat after an error beat");

  a_no_stall_take: assert property (@(posedge clk) disable iff (rst)
    (!in_valid) |-> s_tready)
    else $error("input refused with empty input register");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the ssh packet deframer
// Byte beats are offered through the slave stream; a predictor built into the
// bench follows the framing state and queues any beat that a byte must produce.
// Every master beat is checked against the oldest queued beat. The run walks
// through several register settings, with sender gaps and receiver stalls,
// and ends on one framing error, after which nothing more may come out.
// ----------------------------------------------------------------------------
module tb;
  import sshd_pkg::*;

  localparam logic [CfgIdxW-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SPARE_B = 2'd3;

  typedef enum logic [2:0] {
    AWAIT_LENGTH,
    AWAIT_PADLEN,
    IN_PAYLOAD,
    IN_PADDING,
    LOCKED
  } frame_phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;
  logic [2:0]  m_tuser;

  // predictor copy of registers and framing state
  logic            cipher_on = 1'b0;
  logic [MaxW-1:0] max_bytes = MAX_BYTES_RESET;
  frame_phase_t    frame_phase = AWAIT_LENGTH;
  logic [LenW-1:0] length_acc = '0;
  logic [2:0]      length_seen = '0;
  logic [LenW-1:0] payload_left = '0;
  logic [7:0]      padding_left = '0;
  logic [SeqW-1:0] seq_num = '0;

  sshd_result_t expected_beats[$];
  sshd_result_t want_beat;
  sshd_result_t got_beat;
  int unsigned  mismatches = 0;

  bit           gaps_on = 1'b1;
  logic         m_hold = 1'b0;
  int unsigned  ready_gap = 0;

  ssh_packet_deframer_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  always #2 clk = ~clk;

  function automatic void queue_beat(input logic [7:0] b, input logic lst, input sshd_err_t err);
    sshd_result_t r;
    r.payload_byte = b;
    r.last         = lst;
    r.packet_seq   = seq_num;
    r.error_code   = err;
    expected_beats.insert(expected_beats.size(), r);
    if (err != ERR_NONE) frame_phase = LOCKED;
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    logic [32:0] total;
    logic        misaligned;
    case (frame_phase)
      AWAIT_LENGTH: begin
        length_acc  = {length_acc[23:0], b};
        length_seen = length_seen + 3'd1;
        if (length_seen == 3'd4) begin
          total      = {1'b0, length_acc} + 33'd4;
          misaligned = cipher_on ? (total[3:0] != 4'd0) : (total[2:0] != 3'd0);
          if (length_acc < MIN_LENGTH) queue_beat(8'h00, 1'b0, ERR_LEN_SHORT);
          else if (total > {17'd0, max_bytes}) queue_beat(8'h00, 1'b0, ERR_LEN_LONG);
          else if (misaligned) queue_beat(8'h00, 1'b0, ERR_MISALIGN);
          else frame_phase = AWAIT_PADLEN;
        end
      end
      AWAIT_PADLEN: begin
        if (b < MIN_PADDING) begin
          queue_beat(8'h00, 1'b0, ERR_PAD_SHORT);
        end else if ({25'd0, b} + 33'd2 > {1'b0, length_acc}) begin
          queue_beat(8'h00, 1'b0, ERR_PAD_LONG);
        end else begin
          padding_left = b;
          payload_left = length_acc - 32'd1 - {24'd0, b};
          frame_phase  = IN_PAYLOAD;
        end
      end
      IN_PAYLOAD: begin
        payload_left = payload_left - 32'd1;
        queue_beat(b, payload_left == '0, ERR_NONE);
        if (payload_left == '0) frame_phase = IN_PADDING;
      end
      IN_PADDING: begin
        padding_left = padding_left - 8'd1;
        if (padding_left == 8'd0) begin
          seq_num     = seq_num + 32'd1;
          length_acc  = '0;
          length_seen = '0;
          frame_phase = AWAIT_LENGTH;
        end
      end
      default: ;
    endcase
  endfunction

  // result check first, then prediction for the byte taken on this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got_beat.payload_byte = m_tdata[7:0];
        got_beat.packet_seq   = m_tdata[39:8];
        got_beat.last         = m_tlast;
        got_beat.error_code   = m_tuser;
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected beat byte=%h last=%b seq=%h err=%0d", $time,
                   got_beat.payload_byte, got_beat.last, got_beat.packet_seq,
                   got_beat.error_code);
          mismatches++;
        end else begin
          want_beat = expected_beats.pop_front();
          if (got_beat.payload_byte !== want_beat.payload_byte ||
              got_beat.last !== want_beat.last ||
              got_beat.packet_seq !== want_beat.packet_seq ||
              got_beat.error_code !== want_beat.error_code) begin
            $display("%0t: mismatch expected byte=%h last=%b seq=%h err=%0d", $time,
                     want_beat.payload_byte, want_beat.last, want_beat.packet_seq,
                     want_beat.error_code);
            $display("%0t:          actual   byte=%h last=%b seq=%h err=%0d", $time,
                     got_beat.payload_byte, got_beat.last, got_beat.packet_seq,
                     got_beat.error_code);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) deframe_byte(s_tdata);
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (m_hold) begin
      m_tready <= 1'b0;
    end else if (ready_gap != 0) begin
      m_tready  <= 1'b0;
      ready_gap <= ready_gap - 1;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      m_tready  <= 1'b0;
      ready_gap <= $urandom_range(0, 15);
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic hold_receiver(input int unsigned cycles);
    fork
      begin
        m_hold <= 1'b1;
        repeat (cycles) @(posedge clk);
        m_hold <= 1'b0;
      end
    join_none
  endtask

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_body(input logic [31:0] len, input logic [7:0] pad, input int fill);
    int payload_len;
    payload_len = int'(len) - 1 - int'(pad);
    send_byte(pad);
    for (int i = 0; i < payload_len; i++) send_byte(fill < 0 ? 8'($urandom) : 8'(fill));
    for (int i = 0; i < int'(pad); i++) send_byte(8'($urandom));
  endtask

  task automatic send_frame(input logic [31:0] len, input logic [7:0] pad, input int fill);
    for (int i = 3; i >= 0; i--) send_byte(len[8*i +: 8]);
    send_body(len, pad, fill);
  endtask

  // well-formed packet under the current settings, mostly short
  task automatic random_packet(output int unsigned n);
    int unsigned align, kmin, khi, k, len, pad_hi;
    align = cipher_on ? 16 : 8;
    kmin  = 16 / align;
    khi   = ($urandom_range(0, 15) == 0) ? 640 / align : kmin + 3;
    if (khi > max_bytes / align) khi = max_bytes / align;
    k      = $urandom_range(kmin, khi);
    len    = k * align - 4;
    pad_hi = (len - 2 > 255) ? 255 : len - 2;
    send_frame(len, 8'($urandom_range(4, pad_hi)), -1);
    n = len + 4;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_CIPHER_ACTIVE) cipher_on = val[0];
    else if (idx == REG_MAX_BYTES) max_bytes = val;
  endtask

  task automatic configure(input logic c, input logic [15:0] m);
    write_reg(REG_CIPHER_ACTIVE, {15'($urandom), c});
    write_reg(REG_MAX_BYTES, m);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed_packets();
    send_frame(32'd12, 8'd4, 8'h00);
    send_frame(32'd12, 8'd10, 8'hFF);
    send_frame(32'd260, 8'd255, -1);
    send_frame(32'd20, 8'd4, -1);
    wait_drained();
  endtask

  task automatic test_register_settings();
    configure(1'b1, 16'hFFFF);
    send_frame(32'd28, 8'd4, -1);
    send_frame(32'd44, 8'd17, -1);
    wait_drained();
    configure(1'b0, 16'd16);
    send_frame(32'd12, 8'd6, -1);
    wait_drained();
    configure(1'b1, 16'd16);
    send_frame(32'd12, 8'd4, -1);
    wait_drained();
    // writes to unused indexes leave both registers alone
    write_reg(REG_SPARE_A, 16'($urandom));
    write_reg(REG_SPARE_B, 16'($urandom));
    cfg_valid <= 1'b0;
    send_frame(32'd12, 8'd5, -1);
    wait_drained();
  endtask

  // settings are taken when the fourth length byte arrives
  task automatic test_mid_packet_update();
    configure(1'b1, 16'd16);
    send_byte(8'h00);
    send_byte(8'h00);
    wait_drained();
    configure(1'b0, 16'd35000);
    send_byte(8'h00);
    send_byte(8'd20);
    send_body(32'd20, 8'd8, -1);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int unsigned sent, pkts, n;
    logic [15:0] m;
    sent = 0;
    pkts = 0;
    while (sent < 1200) begin
      if (pkts % 12 == 0) begin
        wait_drained();
        case ($urandom_range(0, 3))
          0: m = 16'd16;
          1: m = 16'hFFFF;
          2: m = MAX_BYTES_RESET;
          default: m = 16'($urandom_range(16, 65535));
        endcase
        configure(1'($urandom), m);
      end
      gaps_on = (sent < 950) && ($urandom_range(0, 3) != 0);
      if (pkts == 5) hold_receiver(400);
      random_packet(n);
      sent += n;
      pkts++;
    end
    wait_drained();
  endtask

  // one framing error per run, then everything is swallowed
  task automatic test_error_lockout();
    sshd_err_t   bad;
    logic [31:0] len;
    bad = sshd_err_t'($urandom_range(1, 5));
    configure(1'($urandom), 16'hFFFF);
    gaps_on = 1'b0;
    case (bad)
      ERR_LEN_SHORT: begin
        len = $urandom_range(0, 11);
        for (int i = 3; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
      ERR_LEN_LONG: begin
        if ($urandom_range(0, 1) == 0) begin
          // maximum below the smallest packet
          wait_drained();
          configure(cipher_on, 16'($urandom_range(0, 15)));
          len = 32'd12;
        end else begin
          case ($urandom_range(0, 2))
            0: len = 32'd65532;
            1: len = $urandom_range(65533, 32'hFFFF_FFFB);
            default: len = 32'hFFFF_FFFC + $urandom_range(0, 3);
          endcase
        end
        for (int i = 3; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
      ERR_MISALIGN: begin
        len = 32'd12 + (cipher_on ? $urandom_range(1, 15) : $urandom_range(1, 7));
        for (int i = 3; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
      ERR_PAD_SHORT: begin
        send_frame(32'd12, 8'd4, -1);
        for (int i = 3; i >= 0; i--) send_byte(len[8*i +: 8] & 8'h00 | (i == 0 ? 8'd28 : 8'd0));
        send_byte(8'($urandom_range(0, 3)));
      end
      default: begin
        len = 32'd28;
        for (int i = 3; i >= 0; i--) send_byte(len[8*i +: 8]);
        send_byte(8'($urandom_range(27, 255)));
      end
    endcase
    repeat (40) send_byte(8'($urandom));
    send_frame(32'd12, 8'd4, -1);
    gaps_on = 1'b0;
  endtask

  initial begin
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed_packets();
    test_register_settings();
    test_mid_packet_update();
    test_random_traffic();
    test_error_lockout();
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
